// ----- rtl/prs_pkg.sv -----
package prs_pkg;

  localparam int PRS_MAX_RECORDS = 16;
  localparam int PRS_ID_W        = 16;
  localparam int PRS_ARR_W       = 16;
  localparam int PRS_PRIO_W      = 8;

  typedef struct packed {
    logic [PRS_ID_W-1:0]   proc_id;
    logic [PRS_ARR_W-1:0]  arrival;
    logic [PRS_PRIO_W-1:0] prio;
  } prs_rec_t;

  typedef enum logic {
    PRS_MODE_ARRIVAL  = 1'b0,
    PRS_MODE_PRIORITY = 1'b1
  } prs_mode_t;

  typedef enum logic [1:0] {
    PRS_LOAD,
    PRS_SORT,
    PRS_EMIT
  } prs_state_t;

  // Control broadcast along the cell chain.
  typedef struct packed {
    logic      sort_en;
    logic      phase;
    logic      shift;
    prs_mode_t mode;
  } prs_ctl_t;

  // True when record x must be ordered after record y.
  function automatic logic prs_goes_after(prs_rec_t x, prs_rec_t y, prs_mode_t mode);
    logic res;
    if (mode == PRS_MODE_PRIORITY && x.prio != y.prio) begin
      res = (x.prio < y.prio);
    end else begin
      res = (x.arrival > y.arrival);
    end
    return res;
  endfunction

endpackage

// ----- rtl/prs_cell.sv -----
module prs_cell
  import prs_pkg::*;
(
  input  logic     clk,
  input  prs_ctl_t ctl,
  input  logic     load_en,
  input  prs_rec_t load_rec,
  input  logic     pair_ok,
  input  logic     left_swap,
  input  prs_rec_t left_rec,
  input  prs_rec_t right_rec,
  output logic     swap_out,
  output prs_rec_t rec
);

  prs_rec_t rec_r;
  prs_rec_t rec_nxt;

  // Compare-exchange with the right neighbor; pairs are disjoint per phase.
  assign swap_out = ctl.sort_en && pair_ok && prs_goes_after(rec_r, right_rec, ctl.mode);

  always_comb begin
    priority if (load_en) begin
      rec_nxt = load_rec;
    end else if (ctl.shift || swap_out) begin
      rec_nxt = right_rec;
    end else if (left_swap) begin
      rec_nxt = left_rec;
    end else begin
      rec_nxt = rec_r;
    end
  end

  always_ff @(posedge clk) begin
    rec_r <= rec_nxt;
  end

  assign rec = rec_r;

endmodule

// ----- rtl/process_record_sorter.sv -----
// Channel  | Direction | Ports                                    | Handshake
// ---------+-----------+------------------------------------------+------------------------
// input    | in        | in_proc_id, in_arrival_time,             | start high, busy low
//          |           | in_priority_level, in_last_record        |
// result   | out       | out_proc_id, out_arrival, out_priority,  | out_valid strobe,
//          |           | out_last, out_overflow_flag              | one cycle each
// config   | in        | cfg_sort_mode                            | cfg_valid and cfg_ready
//
// Records load one per cycle, while busy is low, into a chain of MAX_RECORDS cells,
// in input order. A request marked last starts an odd-even transposition sort; each
// round compare-exchanges the neighbor pairs of one parity, alternating between even
// and odd pairs. Then the chain shifts toward cell 0, one result per cycle. Busy
// stays high through sorting and emitting.
// Reset (rst_n, synchronous, active low) empties the chain and clears the mode.
// The receiver cannot stall; results leave through a registered output stage.
module process_record_sorter
  import prs_pkg::*;
#(
  parameter int MAX_RECORDS = PRS_MAX_RECORDS
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  start,
  output logic                  busy,
  input  logic [PRS_ID_W-1:0]   in_proc_id,
  input  logic [PRS_ARR_W-1:0]  in_arrival_time,
  input  logic [PRS_PRIO_W-1:0] in_priority_level,
  input  logic                  in_last_record,
  output logic                  out_valid,
  output logic [PRS_ID_W-1:0]   out_proc_id,
  output logic [PRS_ARR_W-1:0]  out_arrival,
  output logic [PRS_PRIO_W-1:0] out_priority,
  output logic                  out_last,
  output logic                  out_overflow_flag,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic                  cfg_sort_mode
);

  localparam int CNT_W = $clog2(MAX_RECORDS + 1);
  localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_RECORDS);
  localparam logic [CNT_W-1:0] CNT_ONE = CNT_W'(1);

  prs_state_t       state_r, state_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic [CNT_W-1:0] round_r, round_nxt;
  logic             dropped_r, dropped_nxt;
  prs_mode_t        cfg_mode_r, cfg_mode_nxt;
  prs_mode_t        run_mode_r, run_mode_nxt;

  logic             out_valid_r;
  prs_rec_t         out_rec_r;
  logic             out_last_r;
  logic             out_ovf_r;

  logic             accept;
  prs_ctl_t         ctl;
  prs_rec_t         in_rec;
  prs_rec_t         cell_rec  [MAX_RECORDS];
  logic             cell_swap [MAX_RECORDS];

  assign accept    = start && !busy;
  assign cfg_ready = 1'b1;
  assign in_rec    = '{proc_id: in_proc_id, arrival: in_arrival_time, prio: in_priority_level};

  // Mode register: sampled into the run mode when the last request arrives.
  assign cfg_mode_nxt = (cfg_valid && cfg_ready) ? prs_mode_t'(cfg_sort_mode) : cfg_mode_r;
  assign run_mode_nxt = (accept && in_last_record) ? cfg_mode_r : run_mode_r;

  // Next state.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      PRS_LOAD: if (accept && in_last_record) state_nxt = PRS_SORT;
      PRS_SORT: if (round_r == count_r - CNT_ONE) state_nxt = PRS_EMIT;
      PRS_EMIT: if (count_r == CNT_ONE) state_nxt = PRS_LOAD;
      default:  state_nxt = PRS_LOAD;
    endcase
  end

  // Control outputs to the chain.
  always_comb begin
    busy        = (state_r != PRS_LOAD);
    ctl.sort_en = (state_r == PRS_SORT);
    ctl.phase   = round_r[0];
    ctl.shift   = (state_r == PRS_EMIT);
    ctl.mode    = run_mode_r;
  end

  // Counters: count is the fill level, then the records left to emit.
  always_comb begin
    count_nxt   = count_r;
    round_nxt   = round_r;
    dropped_nxt = dropped_r;
    unique case (state_r)
      PRS_LOAD: begin
        round_nxt = '0;
        if (accept) begin
          if (count_r < CNT_MAX) begin
            count_nxt = count_r + CNT_ONE;
          end else begin
            dropped_nxt = 1'b1;
          end
        end
      end
      PRS_SORT: begin
        round_nxt = round_r + CNT_ONE;
      end
      PRS_EMIT: begin
        count_nxt = count_r - CNT_ONE;
        if (count_r == CNT_ONE) dropped_nxt = 1'b0;
      end
      default: begin
        count_nxt = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= PRS_LOAD;
      count_r    <= '0;
      round_r    <= '0;
      dropped_r  <= 1'b0;
      cfg_mode_r <= PRS_MODE_ARRIVAL;
      run_mode_r <= PRS_MODE_ARRIVAL;
      out_valid_r <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      count_r    <= count_nxt;
      round_r    <= round_nxt;
      dropped_r  <= dropped_nxt;
      cfg_mode_r <= cfg_mode_nxt;
      run_mode_r <= run_mode_nxt;
      out_valid_r <= ctl.shift;
    end
  end

  // Output stage: capture the head of the chain as it shifts out.
  always_ff @(posedge clk) begin
    out_rec_r  <= cell_rec[0];
    out_last_r <= (count_r == CNT_ONE);
    out_ovf_r  <= dropped_r;
  end

  // Cell chain. Each cell trades with its right neighbor on its parity phase,
  // only when both cells hold a stored record.
  for (genvar i = 0; i < MAX_RECORDS; i++) begin : g_cell
    localparam logic PAR = 1'(i % 2);
    prs_rec_t left_rec;
    prs_rec_t right_rec;
    logic     left_swap;
    logic     pair_ok;
    logic     load_en;

    if (i == 0) begin : g_head
      assign left_rec  = cell_rec[i];
      assign left_swap = 1'b0;
    end else begin : g_body
      assign left_rec  = cell_rec[i-1];
      assign left_swap = cell_swap[i-1];
    end

    if (i == MAX_RECORDS - 1) begin : g_tail
      assign right_rec = cell_rec[i];
      assign pair_ok   = 1'b0;
    end else begin : g_mid
      assign right_rec = cell_rec[i+1];
      assign pair_ok   = (ctl.phase == PAR) && (count_r > CNT_W'(i + 1));
    end

    assign load_en = accept && (count_r == CNT_W'(i));

    prs_cell u_cell (
      .clk       (clk),
      .ctl       (ctl),
      .load_en   (load_en),
      .load_rec  (in_rec),
      .pair_ok   (pair_ok),
      .left_swap (left_swap),
      .left_rec  (left_rec),
      .right_rec (right_rec),
      .swap_out  (cell_swap[i]),
      .rec       (cell_rec[i])
    );
  end

  assign out_valid         = out_valid_r;
  assign out_proc_id       = out_rec_r.proc_id;
  assign out_arrival       = out_rec_r.arrival;
  assign out_priority      = out_rec_r.prio;
  assign out_last          = out_last_r;
  assign out_overflow_flag = out_ovf_r;

  // Fill level never passes the chain length.
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_MAX)
    else $error("record count beyond chain length");

  // A result only follows an emit cycle.
  a_valid_from_emit: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(state_r == PRS_EMIT))
    else $error("result strobe without emit cycle");

  // The final result of a run frees the block with an empty chain.
  a_last_frees: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_last |-> !busy && count_r == '0 && !dropped_r)
    else $error("block not free after final result");

  // Sorting and emitting always have records to work on.
  a_busy_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    busy |-> count_r != '0)
    else $error("busy with empty chain");

endmodule
